### hw/rtl/dsac_pkg.sv
// Package for the dual stick axis conditioner: payload words, register indexes,
// arctangent table and fixed constants. No dependencies.
package dsac_pkg;

  typedef struct packed {
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic [15:0]        hat_position;
    logic [15:0]        button_bits;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] left_x_scaled;
    logic signed [7:0] left_y_scaled;
    logic [7:0]        left_force;
    logic [14:0]       left_angle;
    logic signed [7:0] right_x_scaled;
    logic signed [7:0] right_y_scaled;
    logic [7:0]        right_force;
    logic [14:0]       right_angle;
    logic [15:0]       hat_out;
    logic [15:0]       buttons_out;
  } out_word_t;

  typedef enum logic [0:0] {
    REG_AXIS_OFFSET = 1'b0,
    REG_DEAD_ZONE   = 1'b1
  } reg_idx_t;

  localparam int CFG_W        = 15;
  localparam int CFG_IDX_W    = 1;
  localparam int CORDIC_STEPS = 20;
  localparam int TABLE_FRAC   = 16;
  localparam int AXIS_W       = 18;   // offset axis, signed
  localparam int CV_W         = 34;   // CORDIC x/y datapath, signed
  localparam int Z_W          = 26;   // angle accumulator, signed
  localparam int TOT_W        = 27;

  localparam logic signed [10:0] OFFSET_RST = 11'sd100;
  localparam logic [14:0]        DZONE_RST  = 15'd1638;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [CV_W-1:0]   cv_t;
  typedef logic signed [Z_W-1:0]    zang_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/dsac_cordic_stage.sv
// One vectoring CORDIC micro-rotation with registered outputs.
// Depends on dsac_pkg.
module dsac_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  dsac_pkg::cv_t   x_i,
  input  dsac_pkg::cv_t   y_i,
  input  dsac_pkg::zang_t z_i,
  output logic         vld_o,
  output dsac_pkg::cv_t   x_o,
  output dsac_pkg::cv_t   y_o,
  output dsac_pkg::zang_t z_o
);

  localparam logic [4:0] STEP_IDX = 5'(STEP);

  dsac_pkg::cv_t   dx, dy, x_r, y_r;
  dsac_pkg::zang_t dz, z_r;
  logic            vld_r;

  // arithmetic shift is a floor shift
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;
  assign dz = dsac_pkg::zang_t'({4'd0, dsac_pkg::atan_lut(STEP_IDX)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    if (!y_i[dsac_pkg::CV_W-1]) begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + dz;
    end else begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - dz;
    end
  end

  assign vld_o = vld_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

### hw/rtl/dsac_stick_lane.sv
// One stick lane: offset, scaling, force and a pipelined CORDIC angle.
// Depends on dsac_pkg and dsac_cordic_stage.
module dsac_stick_lane #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [10:0] offset,
  input  logic [14:0]        dead_zone,
  output logic signed [7:0]  x_scaled,
  output logic signed [7:0]  y_scaled,
  output logic [7:0]         force_o,
  output logic [14:0]        angle
);

  localparam int N  = dsac_pkg::CORDIC_STEPS;
  localparam int SH = dsac_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int TW = dsac_pkg::TOT_W;
  localparam logic signed [TW-1:0] FULL = TW'(360 << dsac_pkg::TABLE_FRAC);
  localparam logic signed [TW-1:0] HALF = TW'(180 << dsac_pkg::TABLE_FRAC);
  localparam logic [TW-1:0] FULL_OUT = TW'(360 << ANGLE_FRAC_BITS);
  localparam logic [TW-1:0] RND = (SH > 0) ? TW'((1 << SH) >> 1) : '0;

  // stage 0: offset
  dsac_pkg::axis_t sx_r, sy_r;
  logic            v0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= vld_i;
    sx_r <= dsac_pkg::axis_t'(raw_x) + dsac_pkg::axis_t'(offset);
    sy_r <= -(dsac_pkg::axis_t'(raw_y) + dsac_pkg::axis_t'(offset));
  end

  // stage 1: scale, force, CORDIC setup
  function automatic logic [7:0] scale(input dsac_pkg::axis_t s);
    logic signed [25:0] p;
    logic [25:0] m;
    logic [10:0] q;
    p = 26'(s) * 26'sd127;
    m = p[25] ? 26'(-p) : 26'(p);
    q = m[25:15];
    if (q > 11'd127) q = 11'd127;
    return p[25] ? 8'(-q) : q[7:0];
  endfunction

  function automatic logic [7:0] frc(input dsac_pkg::axis_t s,
                                     input logic [14:0] dz);
    logic [17:0] a;
    logic [26:0] f;
    a = s[17] ? 18'(-s) : 18'(s);
    f = (27'(a) * 27'd255 + 27'd16384) >> 15;
    if (a <= 18'(dz)) return 8'd0;
    return (f > 27'd255) ? 8'd255 : f[7:0];
  endfunction

  logic [7:0] xs_r, ys_r, fx, fy, fo_r;
  dsac_pkg::cv_t cx0, cy0;
  logic v1_r, xz1_r, xn1_r, yn1_r, yz1_r;
  always_comb begin
    fx  = frc(sx_r, dead_zone);
    fy  = frc(sy_r, dead_zone);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
    xs_r  <= scale(sx_r);
    ys_r  <= scale(sy_r);
    fo_r  <= (fx > fy) ? fx : fy;
    xz1_r <= (sx_r == '0);
    xn1_r <= sx_r[dsac_pkg::AXIS_W-1];
    yn1_r <= sy_r[dsac_pkg::AXIS_W-1];
    yz1_r <= (sy_r == '0);
    cx0   <= dsac_pkg::cv_t'(sx_r[17] ? -sx_r : sx_r) <<< 14;
    cy0   <= dsac_pkg::cv_t'(sy_r[17] ? -sy_r : sy_r) <<< 14;
  end

  // CORDIC pipeline
  dsac_pkg::cv_t   cx [N+1];
  dsac_pkg::cv_t   cy [N+1];
  dsac_pkg::zang_t cz [N+1];
  logic            cv [N+1];
  assign cx[0] = cx0;
  assign cy[0] = cy0;
  assign cz[0] = '0;
  assign cv[0] = v1_r;
  for (genvar g = 0; g < N; g++) begin : g_st
    dsac_cordic_stage #(.STEP(g)) u_st (
      .clk(clk), .rst_n(rst_n), .vld_i(cv[g]), .x_i(cx[g]), .y_i(cy[g]),
      .z_i(cz[g]), .vld_o(cv[g+1]), .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  // delay side data along the CORDIC
  logic [7:0] xs_d [N+1];
  logic [7:0] ys_d [N+1];
  logic [7:0] fo_d [N+1];
  logic [3:0] fl_d [N+1];
  assign xs_d[0] = xs_r;
  assign ys_d[0] = ys_r;
  assign fo_d[0] = fo_r;
  assign fl_d[0] = {xz1_r, xn1_r, yn1_r, yz1_r};
  for (genvar g = 0; g < N; g++) begin : g_dl
    always_ff @(posedge clk) begin
      xs_d[g+1] <= xs_d[g];
      ys_d[g+1] <= ys_d[g];
      fo_d[g+1] <= fo_d[g];
      fl_d[g+1] <= fl_d[g];
    end
  end

  // placement and rounding
  logic signed [TW-1:0] z, tot;
  logic [TW-1:0] units;
  logic xz, xn, yn, yz;
  always_comb begin
    {xz, xn, yn, yz} = fl_d[N];
    z = yz ? '0 : TW'(cz[N]);
    if (!xn) tot = yn ? FULL - z : z;
    else     tot = yn ? HALF + z : HALF - z;
    if (tot < 0)          tot = tot + FULL;
    else if (tot >= FULL) tot = tot - FULL;
    units = (TW'(tot) + RND) >> SH;
    if (units >= FULL_OUT) units = units - FULL_OUT;
    if (xz) units = '0;
  end

  logic [14:0] ang_r;
  logic [7:0]  xo_r, yo_r, fq_r;
  always_ff @(posedge clk) begin
    ang_r <= units[14:0];
    xo_r  <= xs_d[N];
    yo_r  <= ys_d[N];
    fq_r  <= fo_d[N];
  end

  assign x_scaled = xo_r;
  assign y_scaled = yo_r;
  assign force_o  = fq_r;
  assign angle    = ang_r;

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ##(N) cv[N]) else $error("lane pipeline lost a word");
  a_xz: assert property (@(posedge clk) disable iff (!rst_n)
    cv[N] && fl_d[N][3] |=> ang_r == '0) else $error("zero X angle not zero");
  a_frc: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && fo_r != 8'd0 |-> (xs_r != 8'd0 || ys_r != 8'd0 || dead_zone < 15'd258))
    else $error("force without tilt");
`endif

endmodule

### hw/rtl/dual_stick_axis_conditioner.sv
// Top level of the dual stick axis conditioner: config registers, two stick
// lanes and the merging output stage. Depends on dsac_pkg and dsac_stick_lane.
//
// One sample is taken every cycle; busy is never raised. Each result appears on
// out_word with out_valid after the offset register, the scaling and force
// register, the pipelined CORDIC arctangent stages and the quadrant placement
// register. Results cannot be held off by the receiver.
module dual_stick_axis_conditioner #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  dsac_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output dsac_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic [dsac_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [dsac_pkg::CFG_W-1:0]    cfg_data
);

  localparam int LAT = dsac_pkg::CORDIC_STEPS + 3;

  logic signed [10:0] offset_r;
  logic [14:0]        dzone_r;
  logic               acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= dsac_pkg::OFFSET_RST;
      dzone_r  <= dsac_pkg::DZONE_RST;
    end else if (cfg_we) begin
      case (dsac_pkg::reg_idx_t'(cfg_idx))
        dsac_pkg::REG_AXIS_OFFSET: offset_r <= cfg_data[10:0];
        dsac_pkg::REG_DEAD_ZONE:   dzone_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid and pass-through words track the lanes
  logic [LAT-1:0] vld_r;
  logic [15:0]    hat_d [LAT];
  logic [15:0]    btn_d [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], acc};
    hat_d[0] <= in_word.hat_position;
    btn_d[0] <= in_word.button_bits;
    for (int i = 1; i < LAT; i++) begin
      hat_d[i] <= hat_d[i-1];
      btn_d[i] <= btn_d[i-1];
    end
  end

  logic signed [7:0] lx, ly, rx, ry;
  logic [7:0]  lf, rf;
  logic [14:0] la, ra;

  dsac_stick_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_left (
    .clk(clk), .rst_n(rst_n), .vld_i(acc),
    .raw_x(in_word.left_x_raw), .raw_y(in_word.left_y_raw),
    .offset(offset_r), .dead_zone(dzone_r),
    .x_scaled(lx), .y_scaled(ly), .force_o(lf), .angle(la)
  );

  dsac_stick_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_right (
    .clk(clk), .rst_n(rst_n), .vld_i(acc),
    .raw_x(in_word.right_x_raw), .raw_y(in_word.right_y_raw),
    .offset(offset_r), .dead_zone(dzone_r),
    .x_scaled(rx), .y_scaled(ry), .force_o(rf), .angle(ra)
  );

  // merge lane results into the output word
  assign out_valid = vld_r[LAT-1];
  always_comb begin
    out_word.left_x_scaled  = lx;
    out_word.left_y_scaled  = ly;
    out_word.left_force     = lf;
    out_word.left_angle     = la;
    out_word.right_x_scaled = rx;
    out_word.right_y_scaled = ry;
    out_word.right_force    = rf;
    out_word.right_angle    = ra;
    out_word.hat_out        = hat_d[LAT-1];
    out_word.buttons_out    = btn_d[LAT-1];
  end

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT) out_valid) else $error("word lost in pipeline");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT) out_word.buttons_out == $past(in_word.button_bits, LAT))
    else $error("button word mismatch");
  a_ang: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.left_angle < 15'(360 << ANGLE_FRAC_BITS))
    else $error("angle out of range");
`endif

endmodule
